// File: rtl/sawc_pkg.sv
package sawc_pkg;

   localparam int ADDR_W = 16;
   localparam int DATA_W = 32;

   localparam logic REQ_READ  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_EVICT,
      ST_FILL,
      ST_MEMRD,
      ST_RESP
   } state_type;

endpackage

// File: rtl/set_assoc_lru_writeback_cache_core.sv
// Set-associative write-allocate cache with a built-in backing memory.
// Requests arrive on the req_ channel (valid/stall): a read or a write of one
// 32-bit word at a byte address whose low two bits are ignored. Each request
// produces exactly one word on the rsp_ channel carrying the hit flag, the
// cached word on a read hit, the backing memory word after the access, and
// the write-back address of an evicted line.
// The block works on one request at a time. A read or a write hit passes
// through the lookup, memory-read and response states before its result is
// loaded into the result register, and the next request is taken in the
// idle state after that; a write miss first refills the line word by word,
// preceded by a write-back of the victim line when the set is full. The single
// port of the backing memory and of the cache data memory sets this pacing.
// After reset the block runs a clearing pass over max(MEMORY_BYTES/4, number
// of sets) addresses that zeroes the backing memory and the tag and valid rows
// and gives each way its index as age; req_stall stays high during that pass.
// Results wait in an output register while rsp_stall is high; a finished request
// waits in the response state until it is loaded there; no request is taken meanwhile.
// Geometry is expected to be powers of two.
module set_assoc_lru_writeback_cache_core #(
   parameter int LINE_BYTES   = 16,
   parameter int NUM_WAYS     = 4,
   parameter int CACHE_BYTES  = 1024,
   parameter int MEMORY_BYTES = 65536
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_type,
   input  logic [sawc_pkg::ADDR_W-1:0]  req_byte_address,
   input  logic [sawc_pkg::DATA_W-1:0]  req_write_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_hit,
   output logic [sawc_pkg::DATA_W-1:0]  rsp_cache_word,
   output logic [sawc_pkg::DATA_W-1:0]  rsp_memory_word,
   output logic                         rsp_evicted,
   output logic [sawc_pkg::ADDR_W-1:0]  rsp_victim_line_address
);

   localparam int LINE_WORDS  = LINE_BYTES / 4;
   localparam int SETS_RAW    = CACHE_BYTES / LINE_BYTES / NUM_WAYS;
   localparam int NUM_SETS    = (SETS_RAW == 0) ? 1 : SETS_RAW;
   localparam int SETS_LG     = $clog2(NUM_SETS);
   localparam int SET_W       = (SETS_LG == 0) ? 1 : SETS_LG;
   localparam int OFF_W       = $clog2(LINE_BYTES);
   localparam int TAG_RAW     = sawc_pkg::ADDR_W - OFF_W - SETS_LG;
   localparam int TAG_W       = (TAG_RAW < 1) ? 1 : TAG_RAW;
   localparam int WAY_W       = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
   localparam int AGE_W       = WAY_W;
   localparam int CACHE_WORDS = NUM_SETS * NUM_WAYS * LINE_WORDS;
   localparam int CW_AW       = (CACHE_WORDS > 1) ? $clog2(CACHE_WORDS) : 1;
   localparam int MEM_WORDS   = MEMORY_BYTES / 4;
   localparam int MEM_AW      = $clog2(MEM_WORDS);
   localparam int CLR_N       = (MEM_WORDS > NUM_SETS) ? MEM_WORDS : NUM_SETS;
   localparam int CLR_W       = $clog2(CLR_N);
   localparam int CNT_W       = $clog2(LINE_WORDS + 1);

   typedef logic [NUM_WAYS-1:0]            valid_row_type;
   typedef logic [NUM_WAYS-1:0][AGE_W-1:0] age_row_type;
   typedef logic [NUM_WAYS-1:0][TAG_W-1:0] tag_row_type;

   sawc_pkg::state_type state_ff, state_in;

   logic [CLR_W-1:0] clr_ff, clr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic                        op_ff;
   logic [sawc_pkg::ADDR_W-1:0] addr_ff;
   logic [sawc_pkg::DATA_W-1:0] data_ff;
   logic                        load_req;
   logic                        load_rsp;

   logic [sawc_pkg::DATA_W-1:0] main_mem [MEM_WORDS];
   logic [sawc_pkg::DATA_W-1:0] mem_rdata_ff;
   logic                        mem_we, mem_re;
   logic [MEM_AW-1:0]           mem_addr;
   logic [sawc_pkg::DATA_W-1:0] mem_wdata;

   logic [sawc_pkg::DATA_W-1:0] cache_mem [CACHE_WORDS];
   logic [sawc_pkg::DATA_W-1:0] c_rdata_ff;
   logic                        c_we, c_re;
   logic [CW_AW-1:0]            c_addr;
   logic [sawc_pkg::DATA_W-1:0] c_wdata;

   valid_row_type meta_valid_mem [NUM_SETS];
   age_row_type   meta_age_mem   [NUM_SETS];
   tag_row_type   meta_tag_mem   [NUM_SETS];
   valid_row_type row_valid_ff;
   age_row_type   row_ages_ff;
   tag_row_type   row_tags_ff;
   logic          meta_we, meta_re;
   logic [SET_W-1:0] meta_addr;
   valid_row_type meta_wvalid;
   age_row_type   meta_wages;
   tag_row_type   meta_wtags;
   age_row_type   reset_ages;

   logic                        lk_hit, lk_full;
   logic [WAY_W-1:0]            lk_way;
   age_row_type                 lk_new_ages;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_hit_ff;
   logic [sawc_pkg::DATA_W-1:0] rsp_cache_word_ff;
   logic [sawc_pkg::DATA_W-1:0] rsp_memory_word_ff;
   logic                        rsp_evicted_ff;
   logic [sawc_pkg::ADDR_W-1:0] rsp_victim_ff;

   logic [31:0]      line32, set32, tag32, word32, req_line32, req_set32;
   logic [31:0]      cnt32, vline32, vaddr32, vword32, fword32, aword32;
   logic [TAG_W-1:0] tag_cur;
   logic             evict_now;

   function automatic logic [CW_AW-1:0] cidx(logic [31:0] s, logic [31:0] w,
                                            logic [31:0] wd);
      logic [31:0] t;
      t = (s * NUM_WAYS + w) * LINE_WORDS + wd;
      return t[CW_AW-1:0];
   endfunction

   always_comb begin
      for (int w = 0; w < NUM_WAYS; w++) begin
         reset_ages[w] = AGE_W'(w);
      end
   end

   assign line32     = 32'(addr_ff) >> OFF_W;
   assign set32      = line32 % NUM_SETS;
   assign tag32      = line32 >> SETS_LG;
   assign tag_cur    = tag32[TAG_W-1:0];
   assign word32     = (32'(addr_ff) >> 2) % LINE_WORDS;
   assign req_line32 = 32'(req_byte_address) >> OFF_W;
   assign req_set32  = req_line32 % NUM_SETS;
   assign cnt32      = 32'(cnt_ff);
   assign vline32    = 32'(row_tags_ff[lk_way]) * NUM_SETS + set32;
   assign vaddr32    = vline32 * LINE_BYTES;
   assign vword32    = vline32 * LINE_WORDS;
   assign fword32    = line32 * LINE_WORDS;
   assign aword32    = 32'(addr_ff) >> 2;
   assign evict_now  = (op_ff == sawc_pkg::REQ_WRITE) && !lk_hit && lk_full;

   sawc_way_select #(
      .NUM_WAYS(NUM_WAYS),
      .AGE_W   (AGE_W),
      .TAG_W   (TAG_W),
      .WAY_W   (WAY_W)
   ) u_way_select (
      .row_valid(row_valid_ff),
      .row_ages (row_ages_ff),
      .row_tags (row_tags_ff),
      .tag      (tag_cur),
      .hit      (lk_hit),
      .full     (lk_full),
      .sel_way  (lk_way),
      .new_ages (lk_new_ages)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sawc_pkg::ST_CLEAR: begin
            if (clr_ff == CLR_W'(CLR_N - 1)) state_in = sawc_pkg::ST_IDLE;
         end
         sawc_pkg::ST_IDLE: begin
            if (req_valid) state_in = sawc_pkg::ST_LOOKUP;
         end
         sawc_pkg::ST_LOOKUP: begin
            if (op_ff == sawc_pkg::REQ_WRITE && !lk_hit) begin
               state_in = lk_full ? sawc_pkg::ST_EVICT : sawc_pkg::ST_FILL;
            end else begin
               state_in = sawc_pkg::ST_MEMRD;
            end
         end
         sawc_pkg::ST_EVICT: begin
            if (cnt_ff == CNT_W'(LINE_WORDS)) state_in = sawc_pkg::ST_FILL;
         end
         sawc_pkg::ST_FILL: begin
            if (cnt_ff == CNT_W'(LINE_WORDS)) state_in = sawc_pkg::ST_MEMRD;
         end
         sawc_pkg::ST_MEMRD: state_in = sawc_pkg::ST_RESP;
         sawc_pkg::ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = sawc_pkg::ST_IDLE;
         end
         default: state_in = sawc_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      mem_addr    = '0;
      mem_wdata   = '0;
      c_we        = 1'b0;
      c_re        = 1'b0;
      c_addr      = '0;
      c_wdata     = data_ff;
      meta_we     = 1'b0;
      meta_re     = 1'b0;
      meta_addr   = '0;
      meta_wvalid = row_valid_ff;
      meta_wages  = lk_new_ages;
      meta_wtags  = row_tags_ff;
      cnt_in      = cnt_ff;
      clr_in      = clr_ff;
      load_req    = 1'b0;
      load_rsp    = 1'b0;
      case (state_ff)
         sawc_pkg::ST_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = MEM_AW'(clr_ff);
            if (32'(clr_ff) < NUM_SETS) begin
               meta_we     = 1'b1;
               meta_addr   = SET_W'(clr_ff);
               meta_wvalid = '0;
               meta_wages  = reset_ages;
               meta_wtags  = '0;
            end
            clr_in = clr_ff + CLR_W'(1);
         end
         sawc_pkg::ST_IDLE: begin
            if (req_valid) begin
               load_req  = 1'b1;
               meta_re   = 1'b1;
               meta_addr = req_set32[SET_W-1:0];
            end
         end
         sawc_pkg::ST_LOOKUP: begin
            cnt_in = '0;
            if (op_ff == sawc_pkg::REQ_READ) begin
               if (lk_hit) begin
                  c_re   = 1'b1;
                  c_addr = cidx(set32, 32'(lk_way), word32);
               end
            end else if (lk_hit) begin
               c_we      = 1'b1;
               c_addr    = cidx(set32, 32'(lk_way), word32);
               meta_we   = 1'b1;
               meta_addr = set32[SET_W-1:0];
            end
         end
         sawc_pkg::ST_EVICT: begin
            if (cnt_ff != CNT_W'(LINE_WORDS)) begin
               c_re   = 1'b1;
               c_addr = cidx(set32, 32'(lk_way), cnt32);
            end
            if (cnt_ff != '0) begin
               mem_we    = 1'b1;
               mem_addr  = MEM_AW'(vword32 + cnt32 - 32'd1);
               mem_wdata = c_rdata_ff;
            end
            cnt_in = (cnt_ff == CNT_W'(LINE_WORDS)) ? '0 : cnt_ff + CNT_W'(1);
         end
         sawc_pkg::ST_FILL: begin
            if (cnt_ff != CNT_W'(LINE_WORDS)) begin
               mem_re   = 1'b1;
               mem_addr = MEM_AW'(fword32 + cnt32);
            end
            if (cnt_ff != '0) begin
               c_we    = 1'b1;
               c_addr  = cidx(set32, 32'(lk_way), cnt32 - 32'd1);
               c_wdata = (cnt32 - 32'd1 == word32) ? data_ff : mem_rdata_ff;
            end
            if (cnt_ff == CNT_W'(LINE_WORDS)) begin
               meta_we             = 1'b1;
               meta_addr           = set32[SET_W-1:0];
               meta_wvalid[lk_way] = 1'b1;
               meta_wtags[lk_way]  = tag_cur;
            end
            cnt_in = (cnt_ff == CNT_W'(LINE_WORDS)) ? '0 : cnt_ff + CNT_W'(1);
         end
         sawc_pkg::ST_MEMRD: begin
            mem_re   = 1'b1;
            mem_addr = MEM_AW'(aword32);
         end
         sawc_pkg::ST_RESP: begin
            load_rsp = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            load_rsp = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sawc_pkg::ST_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_req) begin
         op_ff   <= req_type;
         addr_ff <= req_byte_address;
         data_ff <= req_write_data;
      end
      if (load_rsp) begin
         rsp_hit_ff         <= lk_hit;
         rsp_cache_word_ff  <= (op_ff == sawc_pkg::REQ_READ && lk_hit) ? c_rdata_ff : '0;
         rsp_memory_word_ff <= mem_rdata_ff;
         rsp_evicted_ff     <= evict_now;
         rsp_victim_ff      <= evict_now ? vaddr32[sawc_pkg::ADDR_W-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) main_mem[mem_addr] <= mem_wdata;
      if (mem_re) mem_rdata_ff <= main_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (c_we) cache_mem[c_addr] <= c_wdata;
      if (c_re) c_rdata_ff <= cache_mem[c_addr];
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_valid_mem[meta_addr] <= meta_wvalid;
         meta_age_mem[meta_addr]   <= meta_wages;
         meta_tag_mem[meta_addr]   <= meta_wtags;
      end
      if (meta_re) begin
         row_valid_ff <= meta_valid_mem[meta_addr];
         row_ages_ff  <= meta_age_mem[meta_addr];
         row_tags_ff  <= meta_tag_mem[meta_addr];
      end
   end

   assign req_stall               = (state_ff != sawc_pkg::ST_IDLE);
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_hit                 = rsp_hit_ff;
   assign rsp_cache_word          = rsp_cache_word_ff;
   assign rsp_memory_word         = rsp_memory_word_ff;
   assign rsp_evicted             = rsp_evicted_ff;
   assign rsp_victim_line_address = rsp_victim_ff;

endmodule

// File: rtl/sawc_way_select.sv
module sawc_way_select #(
   parameter int NUM_WAYS = 4,
   parameter int AGE_W    = 2,
   parameter int TAG_W    = 8,
   parameter int WAY_W    = 2
) (
   input  logic [NUM_WAYS-1:0]            row_valid,
   input  logic [NUM_WAYS-1:0][AGE_W-1:0] row_ages,
   input  logic [NUM_WAYS-1:0][TAG_W-1:0] row_tags,
   input  logic [TAG_W-1:0]               tag,
   output logic                           hit,
   output logic                           full,
   output logic [WAY_W-1:0]               sel_way,
   output logic [NUM_WAYS-1:0][AGE_W-1:0] new_ages
);

   always_comb begin
      logic [WAY_W-1:0] hit_way;
      logic [WAY_W-1:0] free_way;
      logic [WAY_W-1:0] vic_way;
      logic [AGE_W-1:0] best;
      logic [AGE_W-1:0] old_age;
      logic             free;
      hit      = 1'b0;
      hit_way  = '0;
      free     = 1'b0;
      free_way = '0;
      vic_way  = '0;
      best     = row_ages[0];
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (!hit && row_valid[w] && row_tags[w] == tag) begin
            hit     = 1'b1;
            hit_way = WAY_W'(w);
         end
      end
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (!row_valid[w]) begin
            free     = 1'b1;
            free_way = WAY_W'(w);
         end
      end
      for (int w = 1; w < NUM_WAYS; w++) begin
         if (row_ages[w] > best) begin
            best    = row_ages[w];
            vic_way = WAY_W'(w);
         end
      end
      full    = !free;
      sel_way = hit ? hit_way : (free ? free_way : vic_way);
      old_age = row_ages[sel_way];
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (WAY_W'(w) == sel_way) begin
            new_ages[w] = '0;
         end else if (row_ages[w] <= old_age) begin
            new_ages[w] = row_ages[w] + AGE_W'(1);
         end else begin
            new_ages[w] = row_ages[w];
         end
      end
   end

endmodule

// File: rtl/sawc_checker.sv
module sawc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        req_type,
   input logic [sawc_pkg::ADDR_W-1:0] req_byte_address,
   input logic [sawc_pkg::DATA_W-1:0] req_write_data,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic                        rsp_hit,
   input logic [sawc_pkg::DATA_W-1:0] rsp_cache_word,
   input logic [sawc_pkg::DATA_W-1:0] rsp_memory_word,
   input logic                        rsp_evicted,
   input logic [sawc_pkg::ADDR_W-1:0] rsp_victim_line_address
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_miss_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_cache_word == '0)
      else $error("cache word nonzero on a miss");

   a_victim_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evicted |-> rsp_victim_line_address == '0)
      else $error("victim address without eviction");

   a_evict_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted |-> !rsp_hit)
      else $error("eviction reported on a hit");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while one is in progress");

endmodule

bind set_assoc_lru_writeback_cache_core sawc_checker u_sawc_checker (.*);
